// ===== rtl/ptq_pkg.sv =====
// ptq_pkg: shared types, constants and tables for the pose to quaternion core
// no dependencies; imported by ptq_ctrl, ptq_dp and pose_to_quaternion_and_rates_core
package ptq_pkg;

	// input sample
	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] roll;
		logic signed [31:0] pitch;
		logic signed [31:0] yaw;
		logic [23:0]        interval_us;
		logic               restart;
	} pose_in_t;

	// result
	typedef struct packed {
		logic signed [31:0] quat_w;
		logic signed [31:0] quat_x;
		logic signed [31:0] quat_y;
		logic signed [31:0] quat_z;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] vel_z;
		logic signed [31:0] rate_roll;
		logic signed [31:0] rate_pitch;
		logic signed [31:0] rate_yaw;
		logic               rates_valid;
	} pose_out_t;

	// controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CORD_LOAD,
		ST_CORD_RUN,
		ST_CORD_STORE,
		ST_MUL,
		ST_DIV_LOAD,
		ST_DIV_RUN,
		ST_DIV_STORE,
		ST_OUT
	} ptq_state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic       capture;
		logic       cord_load;
		logic       cord_step;
		logic       cord_store;
		logic       mul_en;
		logic       div_load;
		logic       div_step;
		logic       div_store;
		logic       out_load;
		logic [1:0] ang;
		logic [4:0] iter;
		logic [3:0] mstep;
		logic [2:0] didx;
	} ptq_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic rates_valid;
	} ptq_sts_t;

	localparam int unsigned CORDIC_LAST = 30;
	localparam int unsigned MUL_LAST    = 11;
	localparam int unsigned DIV_LAST    = 5;
	localparam int unsigned DIV_BITS    = 53;

	localparam logic [1:0] ANG_LAST = 2'd2;

	localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
	localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic [19:0]        US_PER_S    = 20'd1000000;

	// arctangent of 2^-i in Q2.30
	function automatic logic [29:0] atan_q30(input logic [4:0] i);
		logic [29:0] r;
		case (i)
			5'd0:    r = 30'h3243F6A8;
			5'd1:    r = 30'h1DAC6705;
			5'd2:    r = 30'h0FADBAFC;
			5'd3:    r = 30'h07F56EA6;
			5'd4:    r = 30'h03FEAB76;
			5'd5:    r = 30'h01FFD55B;
			5'd6:    r = 30'h00FFFAAA;
			5'd7:    r = 30'h007FFF55;
			5'd8:    r = 30'h003FFFEA;
			5'd9:    r = 30'h001FFFFD;
			5'd10:   r = 30'h000FFFFF;
			5'd11:   r = 30'h0007FFFF;
			5'd12:   r = 30'h0003FFFF;
			5'd13:   r = 30'h0001FFFF;
			5'd14:   r = 30'h0000FFFF;
			5'd15:   r = 30'h00007FFF;
			5'd16:   r = 30'h00003FFF;
			5'd17:   r = 30'h00001FFF;
			5'd18:   r = 30'h00000FFF;
			5'd19:   r = 30'h000007FF;
			5'd20:   r = 30'h000003FF;
			5'd21:   r = 30'h000001FF;
			5'd22:   r = 30'h000000FF;
			5'd23:   r = 30'h0000007F;
			5'd24:   r = 30'h0000003F;
			5'd25:   r = 30'h0000001F;
			5'd26:   r = 30'h0000000F;
			5'd27:   r = 30'h00000008;
			5'd28:   r = 30'h00000004;
			5'd29:   r = 30'h00000002;
			5'd30:   r = 30'h00000001;
			default: r = 30'h0;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/pose_to_quaternion_and_rates_core.sv =====
// pose_to_quaternion_and_rates_core: top level, config register and output register
// depends on ptq_pkg, ptq_ctrl, ptq_dp
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall   | in_data (pose_in_t)
//   out     | output    | out_valid/out_stall | out_data (pose_out_t)
//   cfg     | input     | cfg_we              | cfg_data (min_interval_us)
//
// one sample at a time: the shared cordic runs once for each of roll, pitch and yaw,
// then the multiplier forms twelve products, then the divider forms six rates when
// rates are computed. the result waits in the output state until a previous result
// has left the output register; the next input transfer is taken in idle after that.
// the next sample is taken while a finished result waits in the output register.
// reset clears the stored previous sample and sets min_interval_us to 1000.
module pose_to_quaternion_and_rates_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  ptq_pkg::pose_in_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output ptq_pkg::pose_out_t out_data,
	input  logic               cfg_we,
	input  logic [23:0]        cfg_data
);
	import ptq_pkg::*;

	ptq_cmd_t    cmd;
	ptq_sts_t    sts;
	pose_out_t   result;
	pose_out_t   out_q;
	logic        out_valid_q;
	logic        out_free;
	logic [23:0] min_interval_q;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) min_interval_q <= 24'd1000;
		else if (cfg_we) min_interval_q <= cfg_data;
	end

	assign out_free = !out_valid_q || !out_stall;

	ptq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_free (out_free),
		.sts      (sts),
		.cmd      (cmd)
	);

	ptq_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.in_data      (in_data),
		.min_interval (min_interval_q),
		.sts          (sts),
		.result       (result)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) out_q <= result;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// a result appears only after the sequencer loads it
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.out_load))
		else $error("result shown without a load");

	// a transfer on the input closes the input for the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input open while a sample is in work");

	// rates are zero when not computed
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.rates_valid |->
		out_data.vel_x == 0 && out_data.vel_y == 0 && out_data.vel_z == 0 &&
		out_data.rate_roll == 0 && out_data.rate_pitch == 0 && out_data.rate_yaw == 0)
		else $error("rates not cleared");

	// quaternion w stays within +-1.0
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.quat_w <= 32'sd1073741824 &&
		out_data.quat_w >= -32'sd1073741824)
		else $error("quaternion w out of range");

endmodule

// ===== rtl/ptq_ctrl.sv =====
// ptq_ctrl: sequencer for cordic, product and divide phases
// depends on ptq_pkg
module ptq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              out_free,
	input  ptq_pkg::ptq_sts_t sts,
	output ptq_pkg::ptq_cmd_t cmd
);
	import ptq_pkg::*;

	ptq_state_t state_q, state_d;
	logic [1:0] ang_q, ang_d;
	logic [4:0] iter_q, iter_d;
	logic [3:0] mstep_q, mstep_d;
	logic [2:0] didx_q, didx_d;
	logic [5:0] dbit_q, dbit_d;

	// state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ang_q   <= '0;
			iter_q  <= '0;
			mstep_q <= '0;
			didx_q  <= '0;
			dbit_q  <= '0;
		end else begin
			state_q <= state_d;
			ang_q   <= ang_d;
			iter_q  <= iter_d;
			mstep_q <= mstep_d;
			didx_q  <= didx_d;
			dbit_q  <= dbit_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		ang_d    = ang_q;
		iter_d   = iter_q;
		mstep_d  = mstep_q;
		didx_d   = didx_q;
		dbit_d   = dbit_q;
		in_stall = 1'b1;
		cmd      = '0;
		cmd.ang   = ang_q;
		cmd.iter  = iter_q;
		cmd.mstep = mstep_q;
		cmd.didx  = didx_q;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.capture = 1'b1;
					ang_d       = '0;
					state_d     = ST_CORD_LOAD;
				end
			end
			ST_CORD_LOAD: begin
				cmd.cord_load = 1'b1;
				iter_d        = '0;
				state_d       = ST_CORD_RUN;
			end
			ST_CORD_RUN: begin
				cmd.cord_step = 1'b1;
				iter_d        = iter_q + 5'd1;
				if (iter_q == 5'(CORDIC_LAST)) state_d = ST_CORD_STORE;
			end
			ST_CORD_STORE: begin
				cmd.cord_store = 1'b1;
				if (ang_q == ANG_LAST) begin
					mstep_d = '0;
					state_d = ST_MUL;
				end else begin
					ang_d   = ang_q + 2'd1;
					state_d = ST_CORD_LOAD;
				end
			end
			ST_MUL: begin
				cmd.mul_en = 1'b1;
				mstep_d    = mstep_q + 4'd1;
				if (mstep_q == 4'(MUL_LAST)) begin
					didx_d  = '0;
					state_d = sts.rates_valid ? ST_DIV_LOAD : ST_OUT;
				end
			end
			ST_DIV_LOAD: begin
				cmd.div_load = 1'b1;
				dbit_d       = '0;
				state_d      = ST_DIV_RUN;
			end
			ST_DIV_RUN: begin
				cmd.div_step = 1'b1;
				dbit_d       = dbit_q + 6'd1;
				if (dbit_q == 6'(DIV_BITS - 1)) state_d = ST_DIV_STORE;
			end
			ST_DIV_STORE: begin
				cmd.div_store = 1'b1;
				if (didx_q == 3'(DIV_LAST)) begin
					state_d = ST_OUT;
				end else begin
					didx_d  = didx_q + 3'd1;
					state_d = ST_DIV_LOAD;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ===== rtl/ptq_dp.sv =====
// ptq_dp: sample store, shared cordic, q30 multiplier and restoring divider
// depends on ptq_pkg
module ptq_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  ptq_pkg::ptq_cmd_t   cmd,
	input  ptq_pkg::pose_in_t   in_data,
	input  logic [23:0]         min_interval,
	output ptq_pkg::ptq_sts_t   sts,
	output ptq_pkg::pose_out_t  result
);
	import ptq_pkg::*;

	pose_in_t           smp_q;
	logic signed [31:0] prev_q [6];
	logic signed [32:0] diff_q [6];
	logic               have_prior_q;
	logic               valid_q;

	logic signed [31:0] cur [6];
	logic signed [31:0] ang_sel;
	logic signed [35:0] z0, z_red;
	logic               neg_red;

	logic signed [33:0] x_q, y_q;
	logic signed [35:0] z_q;
	logic               neg_q;
	logic signed [33:0] cos_q [3];
	logic signed [33:0] sin_q [3];

	logic signed [33:0] prod_q [12];
	logic signed [33:0] src [10];
	logic [3:0]         sel_a, sel_b;
	logic signed [67:0] prod;
	logic signed [67:0] prod_rnd;

	logic [52:0]        num_q;
	logic [36:0]        rem_q;
	logic [36:0]        den_q;
	logic               dneg_q;
	logic signed [31:0] rate_q [6];
	logic signed [33:0] dsel;
	logic [32:0]        dmag;
	logic [36:0]        rem_sh;
	logic [36:0]        rem_sub;
	logic               rem_ge;

	assign cur[0] = in_data.pos_x;
	assign cur[1] = in_data.pos_y;
	assign cur[2] = in_data.pos_z;
	assign cur[3] = in_data.roll;
	assign cur[4] = in_data.pitch;
	assign cur[5] = in_data.yaw;

	// capture sample, differences against previous, rate enable
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prior_q <= 1'b0;
			valid_q      <= 1'b0;
			for (int k = 0; k < 6; k++) prev_q[k] <= '0;
		end else if (cmd.capture) begin
			have_prior_q <= 1'b1;
			valid_q      <= have_prior_q && !in_data.restart &&
			                (in_data.interval_us > min_interval);
			for (int k = 0; k < 6; k++) prev_q[k] <= cur[k];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			smp_q <= in_data;
			for (int k = 0; k < 6; k++)
				diff_q[k] <= 33'(cur[k]) - 33'(prev_q[k]);
		end
	end

	assign sts.rates_valid = valid_q;

	// half angle and reduction into [-pi/2, pi/2]
	always_comb begin
		case (cmd.ang)
			2'd0:    ang_sel = smp_q.roll;
			2'd1:    ang_sel = smp_q.pitch;
			default: ang_sel = smp_q.yaw;
		endcase
		z0      = {{3{ang_sel[31]}}, ang_sel, 1'b0};
		neg_red = 1'b0;
		z_red   = z0;
		if (z0 > HALF_PI_Q30) begin
			z_red   = z0 - PI_Q30;
			neg_red = 1'b1;
		end else if (z0 < -HALF_PI_Q30) begin
			z_red   = z0 + PI_Q30;
			neg_red = 1'b1;
		end
	end

	// cordic rotation, one iteration a cycle
	always_ff @(posedge clk) begin
		if (cmd.cord_load) begin
			x_q   <= CORDIC_GAIN;
			y_q   <= '0;
			z_q   <= z_red;
			neg_q <= neg_red;
		end else if (cmd.cord_step) begin
			if (!z_q[35]) begin
				x_q <= x_q - (y_q >>> cmd.iter);
				y_q <= y_q + (x_q >>> cmd.iter);
				z_q <= z_q - $signed({6'b0, atan_q30(cmd.iter)});
			end else begin
				x_q <= x_q + (y_q >>> cmd.iter);
				y_q <= y_q - (x_q >>> cmd.iter);
				z_q <= z_q + $signed({6'b0, atan_q30(cmd.iter)});
			end
		end
		if (cmd.cord_store) begin
			cos_q[cmd.ang] <= neg_q ? -x_q : x_q;
			sin_q[cmd.ang] <= neg_q ? -y_q : y_q;
		end
	end

	// product operand sources: trig values then first level products
	assign src[0] = cos_q[0];
	assign src[1] = sin_q[0];
	assign src[2] = cos_q[1];
	assign src[3] = sin_q[1];
	assign src[4] = cos_q[2];
	assign src[5] = sin_q[2];
	assign src[6] = prod_q[0];
	assign src[7] = prod_q[1];
	assign src[8] = prod_q[2];
	assign src[9] = prod_q[3];

	// product schedule
	always_comb begin
		case (cmd.mstep)
			4'd0:    begin sel_a = 4'd0; sel_b = 4'd2; end // cr*cp
			4'd1:    begin sel_a = 4'd1; sel_b = 4'd3; end // sr*sp
			4'd2:    begin sel_a = 4'd1; sel_b = 4'd2; end // sr*cp
			4'd3:    begin sel_a = 4'd0; sel_b = 4'd3; end // cr*sp
			4'd4:    begin sel_a = 4'd6; sel_b = 4'd4; end
			4'd5:    begin sel_a = 4'd7; sel_b = 4'd5; end
			4'd6:    begin sel_a = 4'd8; sel_b = 4'd4; end
			4'd7:    begin sel_a = 4'd9; sel_b = 4'd5; end
			4'd8:    begin sel_a = 4'd9; sel_b = 4'd4; end
			4'd9:    begin sel_a = 4'd8; sel_b = 4'd5; end
			4'd10:   begin sel_a = 4'd6; sel_b = 4'd5; end
			4'd11:   begin sel_a = 4'd7; sel_b = 4'd4; end
			default: begin sel_a = 4'd0; sel_b = 4'd0; end
		endcase
		prod     = 68'(src[sel_a]) * 68'(src[sel_b]);
		prod_rnd = (prod + 68'sd536870912) >>> 30;
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en) prod_q[cmd.mstep] <= prod_rnd[33:0];
	end

	// divider operand set-up
	always_comb begin
		dsel = 34'(diff_q[cmd.didx]);
		dmag = dsel[33] ? 33'(-dsel) : dsel[32:0];
		rem_sh  = {rem_q[35:0], num_q[52]};
		rem_ge  = rem_sh >= den_q;
		rem_sub = rem_sh - den_q;
	end

	// restoring divide, one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			num_q  <= 53'(dmag) * 53'(US_PER_S);
			rem_q  <= '0;
			dneg_q <= dsel[33];
			if (cmd.didx < 3'd3) den_q <= {13'b0, smp_q.interval_us};
			else                 den_q <= {1'b0, smp_q.interval_us, 12'b0};
		end else if (cmd.div_step) begin
			rem_q <= rem_ge ? rem_sub : rem_sh;
			num_q <= {num_q[51:0], rem_ge};
		end
		if (cmd.div_store) begin
			if (dneg_q) begin
				if (num_q >= 53'h80000000) rate_q[cmd.didx] <= 32'sh80000000;
				else                       rate_q[cmd.didx] <= -$signed(num_q[31:0]);
			end else begin
				if (num_q > 53'h7FFFFFFF)  rate_q[cmd.didx] <= 32'sh7FFFFFFF;
				else                       rate_q[cmd.didx] <= $signed(num_q[31:0]);
			end
		end
	end

	// quaternion sums with saturation to +-1.0
	function automatic logic signed [31:0] qsat(input logic signed [34:0] v);
		logic signed [31:0] r;
		if (v > 35'sd1073741824)       r = 32'sd1073741824;
		else if (v < -35'sd1073741824) r = -32'sd1073741824;
		else                           r = v[31:0];
		return r;
	endfunction

	always_comb begin
		result.quat_w = qsat(35'(prod_q[4]) + 35'(prod_q[5]));
		result.quat_x = qsat(35'(prod_q[6]) - 35'(prod_q[7]));
		result.quat_y = qsat(35'(prod_q[8]) + 35'(prod_q[9]));
		result.quat_z = qsat(35'(prod_q[10]) - 35'(prod_q[11]));
		result.vel_x      = valid_q ? rate_q[0] : '0;
		result.vel_y      = valid_q ? rate_q[1] : '0;
		result.vel_z      = valid_q ? rate_q[2] : '0;
		result.rate_roll  = valid_q ? rate_q[3] : '0;
		result.rate_pitch = valid_q ? rate_q[4] : '0;
		result.rate_yaw   = valid_q ? rate_q[5] : '0;
		result.rates_valid = valid_q;
	end

endmodule
